### hdl/sws_pkg.sv
`timescale 1ns / 1ps
package sws_pkg;

	localparam int DATA_W      = 32;
	localparam int MAX_ITEMS   = 64;
	localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QA_W        = $clog2(QUEUE_DEPTH);
	localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} word_t;

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} sort_state_t;

	typedef struct packed {
		sort_state_t      st;
		logic [CNT_W-1:0] count;
		logic             dropped;
	} back_status_t;

endpackage

### hdl/sws_in_if.sv
`timescale 1ns / 1ps
interface sws_in_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] value;
	logic        last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

### hdl/sws_out_if.sv
`timescale 1ns / 1ps
interface sws_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] sorted_value;
	logic        end_of_set;
	logic        overflow;

	modport source (output valid, output sorted_value, output end_of_set, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input end_of_set, input overflow,
		output ready);
endinterface

### hdl/sws_front.sv
`timescale 1ns / 1ps
module sws_front
	import sws_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	sws_in_if.sink in_word,
	output logic  q_valid,
	output word_t q_word,
	input  logic  q_pop
);

	word_t           queue_q [QUEUE_DEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] fill_q;
	logic            push;
	logic            pop;

	assign in_word.ready = (fill_q != QC_W'(QUEUE_DEPTH));
	assign push          = in_word.valid && in_word.ready;
	assign q_valid       = (fill_q != '0);
	assign pop           = q_pop && q_valid;
	assign q_word        = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{value: in_word.value, last: in_word.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### hdl/sws_back.sv
`timescale 1ns / 1ps
module sws_back
	import sws_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  word_t         q_word,
	output logic          q_pop,
	sws_out_if.source     out_word,
	output back_status_t  status
);

	logic signed [DATA_W-1:0] cell_q [MAX_ITEMS];
	logic signed [DATA_W-1:0] cell_nxt [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]     gt;
	logic [CNT_W-1:0]         count_q;
	logic                     dropped_q;
	sort_state_t              st_q;
	sort_state_t              st_nxt;

	logic                     accept_en;
	logic                     drain_en;
	logic                     pop;
	logic                     full;
	logic                     ins;
	logic                     take;

	logic signed [DATA_W-1:0] sorted_value_q;
	logic                     end_of_set_q;
	logic                     overflow_q;
	logic                     out_valid_q;

	assign full  = (count_q == CNT_W'(MAX_ITEMS));
	assign pop   = accept_en && q_valid;
	assign ins   = pop && !full;
	assign take  = drain_en && (!out_valid_q || out_word.ready);
	assign q_pop = accept_en;

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_COLLECT: if (pop && q_word.last) st_nxt = ST_DRAIN;
			ST_DRAIN:   if (take && count_q == CNT_W'(1)) st_nxt = ST_COLLECT;
			default:    st_nxt = ST_COLLECT;
		endcase
	end

	always_comb begin
		accept_en = 1'b0;
		drain_en  = 1'b0;
		case (st_q)
			ST_COLLECT: accept_en = 1'b1;
			ST_DRAIN:   drain_en  = 1'b1;
			default: begin
				accept_en = 1'b0;
				drain_en  = 1'b0;
			end
		endcase
	end

	// sorted insert: cells above the slot shift up by one
	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			gt[i] = (CNT_W'(i) < count_q) && (cell_q[i] > q_word.value);
		end
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
				cell_nxt[i] = cell_q[(i > 0) ? i - 1 : 0];
			end else if (gt[i] || CNT_W'(i) == count_q) begin
				cell_nxt[i] = q_word.value;
			end else begin
				cell_nxt[i] = cell_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			for (int i = 0; i < MAX_ITEMS; i++) begin
				cell_q[i] <= cell_nxt[i];
			end
		end else if (take) begin
			for (int i = 0; i < MAX_ITEMS - 1; i++) begin
				cell_q[i] <= cell_q[i + 1];
			end
		end
		if (take) begin
			sorted_value_q <= cell_q[0];
			end_of_set_q   <= (count_q == CNT_W'(1));
			overflow_q     <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_COLLECT;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (ins) begin
				count_q <= count_q + 1'b1;
			end else if (take) begin
				count_q <= count_q - 1'b1;
			end
			if (pop && full) begin
				dropped_q <= 1'b1;
			end else if (take && count_q == CNT_W'(1)) begin
				dropped_q <= 1'b0;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_word.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_word.valid        = out_valid_q;
	assign out_word.sorted_value = sorted_value_q;
	assign out_word.end_of_set   = end_of_set_q;
	assign out_word.overflow     = overflow_q;

	assign status = '{st: st_q, count: count_q, dropped: dropped_q};

endmodule

### hdl/signed_word_merge_sorter_unit.sv
`timescale 1ns / 1ps
// Sorts sets of signed 32-bit words. Words enter through a 4-deep queue and
// are inserted into a 64-cell sorted register chain, one word per cycle
// while it collects. The word flagged last closes the set: the chain then
// drains smallest first, one word per cycle while the sink is ready,
// end_of_set on the greatest. Inserts and drains never overlap, as the cell
// chain has a single insert/drain port; during a drain the queue keeps
// taking words of the next set until it fills. Words beyond 64 in a set
// are dropped and every result of that set carries overflow.
module signed_word_merge_sorter_unit
	import sws_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	sws_in_if.sink    in_word,
	sws_out_if.source out_word
);

	logic         q_valid;
	word_t        q_word;
	logic         q_pop;
	back_status_t status;

	sws_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_word (in_word),
		.q_valid (q_valid),
		.q_word  (q_word),
		.q_pop   (q_pop)
	);

	sws_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_word   (q_word),
		.q_pop    (q_pop),
		.out_word (out_word),
		.status   (status)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.count <= CNT_W'(MAX_ITEMS))
		else $error("cell count above capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		status.st == ST_DRAIN |-> status.count != '0)
		else $error("drain with empty chain");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(status.st == ST_COLLECT && status.dropped) |-> status.count == CNT_W'(MAX_ITEMS))
		else $error("drop flag set with room left");

endmodule
